// File: hdl/itda_pkg.sv
// Shared types, constants and the shift-and-add-three step for the decimal converter.
`timescale 1ns / 1ps

package itda_pkg;

    localparam int VALUE_W          = 32;
    localparam int NUM_DIGITS       = 10;
    localparam int DIGIT_W          = 4;
    localparam int BCD_W            = NUM_DIGITS * DIGIT_W;
    localparam int IDX_W            = $clog2(NUM_DIGITS);
    localparam int CHAR_W           = 6;
    localparam int TDATA_IN_W       = 32;
    localparam int TDATA_OUT_W      = 8;
    localparam int NUM_DABBLE_STAGES = 4;
    localparam int BITS_PER_STAGE   = VALUE_W / NUM_DABBLE_STAGES;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 6'd45;
    localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ   = 4'd3;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

    // Conversion word carried down the pipeline.
    typedef struct packed {
        logic                neg;
        digits_t             digits;
        logic [VALUE_W-1:0]  bin;
    } conv_t;

    // One shift-and-add-three step: correct every digit, then shift one binary bit in.
    function automatic conv_t dabble_step(input conv_t cur);
        conv_t            res;
        logic [BCD_W-1:0] flat;
        res = cur;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (res.digits[d] >= DIGIT_FIVE) begin
                res.digits[d] = res.digits[d] + DIGIT_ADJ;
            end
        end
        flat = res.digits;
        flat = {flat[BCD_W-2:0], res.bin[VALUE_W-1]};
        res.digits = flat;
        res.bin = {res.bin[VALUE_W-2:0], 1'b0};
        return res;
    endfunction

endpackage

// File: hdl/int_to_decimal_ascii_unit.sv
// Top level of the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps

// Channel  | Direction | tdata (low bit up)            | tlast / tuser
// ---------+-----------+-------------------------------+------------------------------
// s_       | in        | value[31:0], signed           | none
// m_       | out       | character[5:0], 2 zero bits   | tlast = last character, no tuser
//
// An accepted value passes a magnitude register, four shift-and-add-three stages of
// eight bits each and the registered emitter before its first character is on m_.
// Each value is sent as 1 to 11 characters, one per cycle while m_tready is high;
// the next value's first character follows its last without a gap when it is waiting.
// Reset (aresetn low, synchronous) empties every stage and the emitter.
// Back-pressure on m_tready holds the current character and stalls the stages in turn.

module int_to_decimal_ascii_unit
    import itda_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [TDATA_IN_W-1:0]   s_tdata,   // [31:0] value
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TDATA_OUT_W-1:0]  m_tdata,   // [5:0] character, [7:6] zero
    output logic                    m_tlast
);

    // Handshake and payload between the stages; entry 0 is the magnitude stage output.
    logic                          stage_valid [NUM_DABBLE_STAGES+1];
    logic                          stage_ready [NUM_DABBLE_STAGES+1];
    conv_t                         stage_data  [NUM_DABBLE_STAGES+1];
    logic [CHAR_W-1:0]             out_char;

    // The magnitude is taken as unsigned so that the most negative value converts exactly.
    itda_mag_stage u_mag (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_W-1:0]),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    // Each stage shifts eight magnitude bits into the ten-digit BCD word.
    for (genvar g = 0; g < NUM_DABBLE_STAGES; g++) begin : g_dabble
        itda_dabble_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    // The emitter drops leading zeros and flags the final character of each value.
    itda_serializer u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stage_valid[NUM_DABBLE_STAGES]),
        .in_ready  (stage_ready[NUM_DABBLE_STAGES]),
        .in_data   (stage_data[NUM_DABBLE_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(TDATA_OUT_W-CHAR_W){1'b0}}, out_char};

endmodule

// File: hdl/itda_mag_stage.sv
// Input register stage: takes the signed value and forms its sign and unsigned magnitude.
`timescale 1ns / 1ps

module itda_mag_stage
    import itda_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [VALUE_W-1:0]  in_value,
    output logic                out_valid,
    input  logic                out_ready,
    output conv_t               out_data
);

    logic  valid_reg, valid_next;
    conv_t data_reg, data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next.neg    = in_value[VALUE_W-1];
        data_next.digits = '0;
        // Unsigned negation, so the most negative value gives 2^31 exactly.
        data_next.bin    = in_value[VALUE_W-1] ? (~in_value + 1'b1) : in_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hdl/itda_dabble_stage.sv
// One pipeline stage of the binary to BCD conversion, handling a slice of the magnitude bits.
`timescale 1ns / 1ps

module itda_dabble_stage
    import itda_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  conv_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output conv_t out_data
);

    logic  valid_reg, valid_next;
    conv_t data_reg, data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next  = in_data;
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            data_next = dabble_step(data_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hdl/itda_serializer.sv
// Character emitter: sends the sign and the significant digits one transaction at a time.
`timescale 1ns / 1ps

module itda_serializer
    import itda_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  conv_t              in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  out_char,
    output logic               out_last
);

    logic             busy_reg, busy_next;
    logic             sign_reg, sign_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    digits_t          digits_reg;
    logic [IDX_W-1:0] top_idx;
    logic             finishing;
    logic             load;

    // Index of the most significant non-zero digit; zero keeps a single digit.
    always_comb begin
        top_idx = '0;
        for (int d = 1; d < NUM_DIGITS; d++) begin
            if (in_data.digits[d] != '0) begin
                top_idx = IDX_W'(d);
            end
        end
    end

    assign finishing = busy_reg && out_ready && !sign_reg && (idx_reg == '0);
    assign in_ready  = !busy_reg || finishing;
    assign load      = in_valid && in_ready;

    always_comb begin
        busy_next = busy_reg;
        sign_next = sign_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            sign_next = in_data.neg;
            idx_next  = top_idx;
        end else if (finishing) begin
            busy_next = 1'b0;
        end else if (busy_reg && out_ready) begin
            if (sign_reg) begin
                sign_next = 1'b0;
            end else begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            sign_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            sign_reg <= sign_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            digits_reg <= in_data.digits;
        end
    end

    assign out_valid = busy_reg;
    assign out_char  = sign_reg ? ASCII_MINUS
                                : (ASCII_ZERO + CHAR_W'(digits_reg[idx_reg]));
    assign out_last  = !sign_reg && (idx_reg == '0);

endmodule
